[hw/rtl/rlp_string_stream_decoder_core_assert.svh]
// Assertion macros shared by the decoder RTL.
// Each macro expands to a labeled concurrent assertion in simulation and to
// nothing in synthesis.
`ifndef RLP_STRING_STREAM_DECODER_CORE_ASSERT_SVH
`define RLP_STRING_STREAM_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside of reset.
`define RLPSD_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define RLPSD_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define RLPSD_ASSERT(label, clock, reset, prop, msg)

`define RLPSD_ASSERT_ALWAYS(label, clock, prop, msg)

`endif

`endif

[hw/rtl/rlpsd_pkg.sv]
package rlpsd_pkg;

  // Longest big-endian length field that is decoded (4 bytes; longer fields give ST_WIDE).
  localparam int LEN_BYTES_MAX = 4;

  // Prefix boundaries.
  localparam logic [7:0] PREFIX_SHORT_BASE = 8'h80;
  localparam logic [7:0] PREFIX_SHORT_MAX  = 8'hb7;
  localparam logic [7:0] PREFIX_LONG_MAX   = 8'hbf;

  // Frame status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_LIST  = 2'd2;
  localparam logic [1:0] ST_WIDE  = 2'd3;

  // Decoder phase, one-hot.
  typedef enum logic [4:0] {
    PH_PREFIX  = 5'b00001,
    PH_LENGTH  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_DONE    = 5'b01000,
    PH_ERROR   = 5'b10000
  } phase_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } rlpsd_in_t;

  // One output transaction.
  typedef struct packed {
    logic [7:0]  out_data;
    logic        data_valid;
    logic        frame_done;
    logic [1:0]  status;
    logic [31:0] payload_length;
    logic [32:0] consumed_count;
  } rlpsd_out_t;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    phase_t      phase;
    logic [31:0] length_accumulator;
    logic [3:0]  length_bytes_left;
    logic [31:0] payload_left;
    logic [32:0] consumed_so_far;
    logic [1:0]  held_status;
  } rlpsd_state_t;

  localparam rlpsd_state_t STATE_INIT = '{
    phase:              PH_PREFIX,
    length_accumulator: 32'd0,
    length_bytes_left:  4'd0,
    payload_left:       32'd0,
    consumed_so_far:    33'd0,
    held_status:        ST_OK
  };

endpackage

[hw/rtl/rlpsd_step.sv]
module rlpsd_step
  import rlpsd_pkg::*;
(
  input  rlpsd_state_t state,
  input  rlpsd_in_t    item,
  output rlpsd_state_t state_next,
  output rlpsd_out_t   result,
  output logic         result_valid
);

  rlpsd_state_t upd;
  logic         dv;
  logic [3:0]   long_count;
  logic [31:0]  short_len;
  logic [31:0]  acc_shifted;
  logic [3:0]   left_dec;
  logic [31:0]  payload_dec;

  // Helper values for the phase update.
  assign long_count  = {1'b0, item.in_byte[2:0]} + 4'd1;
  assign short_len   = {24'd0, item.in_byte - PREFIX_SHORT_BASE};
  assign acc_shifted = {state.length_accumulator[23:0], item.in_byte};
  assign left_dec    = state.length_bytes_left - 4'd1;
  assign payload_dec = state.payload_left - 32'd1;

  // Advance the decoder by one byte.
  always_comb begin
    upd = state;
    dv  = 1'b0;
    unique case (state.phase)
      PH_PREFIX: begin
        upd.consumed_so_far = 33'd1;
        if (item.in_byte < PREFIX_SHORT_BASE) begin
          upd.length_accumulator = 32'd1;
          dv = 1'b1;
          upd.phase = PH_DONE;
        end else if (item.in_byte <= PREFIX_SHORT_MAX) begin
          upd.length_accumulator = short_len;
          upd.payload_left = short_len;
          upd.phase = (short_len == 32'd0) ? PH_DONE : PH_PAYLOAD;
        end else if (item.in_byte <= PREFIX_LONG_MAX) begin
          if (long_count > 4'(LEN_BYTES_MAX)) begin
            upd.held_status = ST_WIDE;
            upd.phase = PH_ERROR;
          end else begin
            upd.length_accumulator = 32'd0;
            upd.length_bytes_left = long_count;
            upd.phase = PH_LENGTH;
          end
        end else begin
          upd.held_status = ST_LIST;
          upd.phase = PH_ERROR;
        end
      end
      PH_LENGTH: begin
        upd.consumed_so_far = state.consumed_so_far + 33'd1;
        if (state.length_accumulator[31:24] != 8'd0) begin
          // The next byte would push the length past 32 bits.
          upd.held_status = ST_WIDE;
          upd.phase = PH_ERROR;
        end else begin
          upd.length_accumulator = acc_shifted;
          upd.length_bytes_left = left_dec;
          if (left_dec == 4'd0) begin
            upd.payload_left = acc_shifted;
            upd.phase = (acc_shifted == 32'd0) ? PH_DONE : PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        upd.consumed_so_far = state.consumed_so_far + 33'd1;
        dv = 1'b1;
        upd.payload_left = payload_dec;
        if (payload_dec == 32'd0) begin
          upd.phase = PH_DONE;
        end
      end
      default: begin
        // Item complete or in error: the byte is ignored.
      end
    endcase
  end

  // Build the result and return to the prefix phase at the frame's end.
  always_comb begin
    result       = '0;
    result_valid = dv || item.in_last;
    state_next   = upd;
    result.data_valid = dv;
    result.out_data   = dv ? item.in_byte : 8'd0;
    if (item.in_last) begin
      result.frame_done     = 1'b1;
      result.consumed_count = upd.consumed_so_far;
      if (upd.phase == PH_DONE) begin
        result.status         = ST_OK;
        result.payload_length = upd.length_accumulator;
      end else if (upd.phase == PH_ERROR) begin
        result.status = upd.held_status;
      end else begin
        result.status = ST_TRUNC;
        if (upd.phase == PH_PAYLOAD) begin
          result.payload_length = upd.length_accumulator;
        end
      end
      state_next = STATE_INIT;
    end
  end

endmodule

[hw/rtl/rlp_string_stream_decoder_core.sv]
// Channel   Direction  Handshake           Payload
// in        sink       in_valid/in_stall   in_item  (rlpsd_in_t: byte, last flag)
// out       source     out_valid/out_stall out_item (rlpsd_out_t: data, frame status)
//
// One byte is taken per clock cycle while the output is not stalled; a result
// passes through the input register and then the output register. The rate is
// set by the single per-byte state update between those two registers.
// Reset (rst, synchronous) empties both registers and puts the decoder at the
// start of a frame.
// A stall on the output holds the result and backs up into in_stall at once.
`include "rlp_string_stream_decoder_core_assert.svh"

module rlp_string_stream_decoder_core
  import rlpsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  rlpsd_in_t  in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output rlpsd_out_t out_item
);

  logic         s1_valid;
  rlpsd_in_t    s1_item;
  logic         s1_adv;
  rlpsd_state_t state;
  rlpsd_state_t state_next;
  rlpsd_out_t   result;
  logic         result_valid;

  // The staged byte moves on whenever the output register can take a result.
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_valid || s1_adv) begin
      s1_item <= in_item;
    end
  end

  // Per-byte decode.
  rlpsd_step u_step (
    .state        (state),
    .item         (s1_item),
    .state_next   (state_next),
    .result       (result),
    .result_valid (result_valid)
  );

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_INIT;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && result_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && result_valid) begin
      out_item <= result;
    end
  end

  // A result that does not close a frame always carries a payload byte.
  `RLPSD_ASSERT(a_result_has_data, clk, rst, out_valid && !out_item.frame_done |-> out_item.data_valid, "result without data or frame end")
  // Without a payload byte the data field reads zero.
  `RLPSD_ASSERT(a_idle_data_zero, clk, rst, out_valid && !out_item.data_valid |-> out_item.out_data == 8'd0, "nonzero data without data_valid")
  // A processed last byte returns the decoder to the prefix phase.
  `RLPSD_ASSERT(a_frame_restart, clk, rst, s1_adv && s1_item.in_last |=> state.phase == PH_PREFIX, "decoder did not restart after frame end")
  // While in the payload phase at least one payload byte is still owed.
  `RLPSD_ASSERT(a_payload_left, clk, rst, state.phase == PH_PAYLOAD |-> state.payload_left != 32'd0, "payload phase with nothing left")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import rlpsd_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  rlpsd_in_t  in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rlpsd_out_t out_item;

  rlp_string_stream_decoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // One row of the directed table; res is only used when typed is set.
  typedef struct {
    logic [7:0] in_b;
    logic       last;
    bit         typed;
    rlpsd_out_t res;
  } stim_row_t;

  localparam rlpsd_out_t NO_RES = '0;

  stim_row_t directed_rows [25] = '{
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, ST_OK,    32'd1,         33'd1}},
    '{8'h7f, 1'b1, 1'b1, '{8'h7f, 1'b1, 1'b1, ST_OK,    32'd1,         33'd1}},
    '{8'h80, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK,    32'd0,         33'd1}},
    '{8'hc0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_LIST,  32'd0,         33'd1}},
    '{8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_LIST,  32'd0,         33'd1}},
    '{8'hbc, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_WIDE,  32'd0,         33'd1}},
    '{8'hbf, 1'b0, 1'b0, NO_RES},
    '{8'h11, 1'b0, 1'b0, NO_RES},
    '{8'h22, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_WIDE,  32'd0,         33'd1}},
    '{8'h81, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'h55, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK,    32'd1,         33'd2}},
    '{8'hb7, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TRUNC, 32'd55,        33'd1}},
    '{8'hb8, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_OK,    32'd0,         33'd2}},
    '{8'hbb, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TRUNC, 32'hffffffff,  33'd5}},
    '{8'hb9, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, ST_TRUNC, 32'd0,         33'd2}},
    '{8'h82, 1'b0, 1'b0, NO_RES},
    '{8'hab, 1'b0, 1'b0, NO_RES},
    '{8'hcd, 1'b1, 1'b1, '{8'hcd, 1'b1, 1'b1, ST_OK,    32'd2,         33'd3}}
  };

  rlpsd_state_t dec_state = STATE_INIT;
  rlpsd_out_t   expected_decode_q [$];

  int cycle_count = 0;
  int error_count = 0;
  int bytes_accepted = 0;
  int frames_checked = 0;
  int payload_bytes_checked = 0;

  // Clock and cycle counter.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Decoder prediction: advances the shadow state by one byte and returns 1
  // when the byte yields a transaction on the output.
  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output rlpsd_out_t res);
    int  field_len;
    bit  emit;
    res = '0;
    emit = 1'b0;
    field_len = int'(b) - int'(PREFIX_SHORT_MAX);
    case (dec_state.phase)
      PH_PREFIX: begin
        dec_state.consumed_so_far = 33'd1;
        if (b < PREFIX_SHORT_BASE) begin
          // A byte below the short base is its own one-byte payload.
          dec_state.length_accumulator = 32'd1;
          emit = 1'b1;
          res.data_valid = 1'b1;
          res.out_data = b;
          dec_state.phase = PH_DONE;
        end else if (b <= PREFIX_SHORT_MAX) begin
          dec_state.length_accumulator = 32'(b - PREFIX_SHORT_BASE);
          dec_state.payload_left = dec_state.length_accumulator;
          if (dec_state.length_accumulator == 32'd0) dec_state.phase = PH_DONE;
          else dec_state.phase = PH_PAYLOAD;
        end else if (b <= PREFIX_LONG_MAX) begin
          if (field_len > LEN_BYTES_MAX) begin
            dec_state.held_status = ST_WIDE;
            dec_state.phase = PH_ERROR;
          end else begin
            dec_state.length_accumulator = 32'd0;
            dec_state.length_bytes_left = 4'(field_len);
            dec_state.phase = PH_LENGTH;
          end
        end else begin
          dec_state.held_status = ST_LIST;
          dec_state.phase = PH_ERROR;
        end
      end
      PH_LENGTH: begin
        dec_state.consumed_so_far = dec_state.consumed_so_far + 33'd1;
        if (dec_state.length_accumulator[31:24] != 8'd0) begin
          // The next shift would push length bits out of 32.
          dec_state.held_status = ST_WIDE;
          dec_state.phase = PH_ERROR;
        end else begin
          dec_state.length_accumulator = {dec_state.length_accumulator[23:0], b};
          dec_state.length_bytes_left = dec_state.length_bytes_left - 4'd1;
          if (dec_state.length_bytes_left == 4'd0) begin
            dec_state.payload_left = dec_state.length_accumulator;
            if (dec_state.length_accumulator == 32'd0) dec_state.phase = PH_DONE;
            else dec_state.phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        dec_state.consumed_so_far = dec_state.consumed_so_far + 33'd1;
        emit = 1'b1;
        res.data_valid = 1'b1;
        res.out_data = b;
        dec_state.payload_left = dec_state.payload_left - 32'd1;
        if (dec_state.payload_left == 32'd0) dec_state.phase = PH_DONE;
      end
      default: begin
      end
    endcase

    // Frame end: report status and counts, then wait for a new prefix.
    if (last) begin
      emit = 1'b1;
      res.frame_done = 1'b1;
      res.consumed_count = dec_state.consumed_so_far;
      case (dec_state.phase)
        PH_DONE: begin
          res.status = ST_OK;
          res.payload_length = dec_state.length_accumulator;
        end
        PH_ERROR: res.status = dec_state.held_status;
        PH_PAYLOAD: begin
          res.status = ST_TRUNC;
          res.payload_length = dec_state.length_accumulator;
        end
        default: res.status = ST_TRUNC;
      endcase
      dec_state = STATE_INIT;
    end
    return emit;
  endfunction

  // Drives one byte after a random gap and waits until the decoder accepts it.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input rlpsd_out_t typed_res);
    int         gap;
    int         r;
    rlpsd_out_t res;
    r = $urandom_range(0, 99);
    if ((cycle_count / 400) % 4 == 2) gap = 0;
    else if (r < 70) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 30);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{in_byte: b, in_last: last};
    do @(posedge clk); while (in_stall);
    bytes_accepted++;
    if (decode_byte(b, last, res)) expected_decode_q.push_back(typed ? typed_res : res);
  endtask

  task automatic check_field(input string field, input logic [32:0] want,
                             input logic [32:0] got);
    if (want !== got) begin
      if (error_count < 10)
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // Output stall with random lengths and quiet stretches.
  initial begin : out_stall_gen
    int hold;
    int r;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if ((cycle_count / 400) % 4 == 0) hold = 0;
      else if (r < 75) hold = 0;
      else if (r < 95) hold = $urandom_range(1, 3);
      else hold = $urandom_range(5, 30);
      if (hold == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every output transaction with the oldest prediction.
  always @(posedge clk) begin : result_check
    rlpsd_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_decode_q.size() == 0) begin
        if (error_count < 10)
          $display("[%0t] unexpected output transaction: %p", $time, out_item);
        error_count++;
      end else begin
        want = expected_decode_q.pop_front();
        check_field("out_data", 33'(want.out_data), 33'(out_item.out_data));
        check_field("data_valid", 33'(want.data_valid), 33'(out_item.data_valid));
        check_field("frame_done", 33'(want.frame_done), 33'(out_item.frame_done));
        check_field("status", 33'(want.status), 33'(out_item.status));
        check_field("payload_length", 33'(want.payload_length),
                    33'(out_item.payload_length));
        check_field("consumed_count", want.consumed_count, out_item.consumed_count);
        if (out_item.frame_done) frames_checked++;
        if (out_item.data_valid) payload_bytes_checked++;
      end
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding", CYCLE_LIMIT,
             expected_decode_q.size());
    $display("Regression FAIL");
    $finish;
  end

  // Main stimulus: directed table, then random frames.
  initial begin : stimulus
    logic [7:0]  frame_q [$];
    logic [31:0] len_val;
    int          random_items;
    int          kind;
    int          plen;
    int          nlen;
    int          r;
    int          body;
    bit          drained;

    random_items = 0;
    drained = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].in_b, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].res);

    while (random_items < RANDOM_ITEMS) begin
      // Halfway through, let the pipeline drain completely once.
      if (!drained && random_items >= RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_decode_q.size() != 0) @(posedge clk);
      end

      frame_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        frame_q.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 55) begin
        // Short form, mostly small payloads.
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 55) : $urandom_range(0, 8);
        frame_q.push_back(8'(int'(PREFIX_SHORT_BASE) + plen));
        repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 80) begin
        // Long form; small values in wide fields give leading zero bytes.
        nlen = $urandom_range(1, LEN_BYTES_MAX);
        plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 60);
        if (nlen == 1) plen = plen % 256;
        len_val = 32'(plen);
        frame_q.push_back(8'(int'(PREFIX_SHORT_MAX) + nlen));
        for (int i = nlen - 1; i >= 0; i--) frame_q.push_back(len_val[8 * i +: 8]);
        repeat (plen) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 85) begin
        // Long form with random length bytes; almost always cut short.
        nlen = $urandom_range(1, LEN_BYTES_MAX);
        frame_q.push_back(8'(int'(PREFIX_SHORT_MAX) + nlen));
        repeat (nlen) frame_q.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 5)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        frame_q.push_back(8'($urandom_range(int'(PREFIX_SHORT_MAX) + LEN_BYTES_MAX + 1,
                                            int'(PREFIX_LONG_MAX))));
        repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 95) begin
        frame_q.push_back(8'($urandom_range(int'(PREFIX_LONG_MAX) + 1, 255)));
        repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
      end

      // Well-formed frames end exactly, early, or with trailing bytes.
      body = frame_q.size();
      if (kind < 80) begin
        r = $urandom_range(0, 99);
        if (r >= 70 && r < 85 && frame_q.size() > 1) begin
          repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
          body = frame_q.size();
        end else if (r >= 85) begin
          repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      random_items += body;

      for (int i = 0; i < frame_q.size(); i++)
        send_byte(frame_q[i], (i == frame_q.size() - 1), 1'b0, NO_RES);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_decode_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes; checked %0d frame results and %0d payload bytes.",
             bytes_accepted, frames_checked, payload_bytes_checked);
    $display("Frames: single, short, long, list, too wide, truncated, trailing; %0d errors.",
             error_count);
    if (error_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
